// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/kpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// kpsc_pkg
// Widths, codes and controller/datapath link types of the permutation cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kpsc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    // pointers must reach one past the last entry
    localparam int unsigned PTR_W       = ADDR_W + 1;
    localparam int unsigned KEY_COUNT   = 16;
    localparam int unsigned KIDX_W      = 4;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned MIN_CHUNK   = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAIR,
        ST_WRITE,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic start;
        logic rd_pair;
        logic wr_first;
        logic flush;
        logic next_chunk;
        logic rd_look;
        logic load_out;
        logic in_ready;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic pair_ok;
        logic tail;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/kpsc_in_if.sv -----
// ----------------------------------------------------------------------------
// kpsc_in_if
// Input byte channel: valid/ready handshake carrying one data byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [kpsc_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- design/kpsc_out_if.sv -----
// ----------------------------------------------------------------------------
// kpsc_out_if
// Result byte channel: valid/ready handshake carrying one result byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpsc_out_if;
    logic                         valid;
    logic                         ready;
    logic [kpsc_pkg::BYTE_W-1:0]  result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

// ----- design/kpsc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// kpsc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kpsc_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [kpsc_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- design/kpsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpsc_ctrl
// Sequencer: table clear, chunk walk, swap phases, lookup and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module kpsc_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  kpsc_pkg::t_dp_status        i_status,
    output kpsc_pkg::t_ctrl_cmd         o_cmd
);

    kpsc_pkg::t_state r_state;
    kpsc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpsc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kpsc_pkg::ST_CLEAR: begin
                if (i_status.clr_last) n_state = kpsc_pkg::ST_IDLE;
            end
            kpsc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = kpsc_pkg::ST_PAIR;
            end
            kpsc_pkg::ST_PAIR: begin
                if (i_status.pair_ok) begin
                    n_state = kpsc_pkg::ST_WRITE;
                end else if (i_status.tail) begin
                    n_state = kpsc_pkg::ST_LOOKUP;
                end
            end
            kpsc_pkg::ST_WRITE: begin
                n_state = kpsc_pkg::ST_PAIR;
            end
            kpsc_pkg::ST_LOOKUP: begin
                n_state = kpsc_pkg::ST_RESULT;
            end
            kpsc_pkg::ST_RESULT: begin
                if (i_status.out_free) n_state = kpsc_pkg::ST_IDLE;
            end
            default: begin
                n_state = kpsc_pkg::ST_CLEAR;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd = '0;
        case (r_state)
            kpsc_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            kpsc_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.start    = i_in_valid;
            end
            kpsc_pkg::ST_PAIR: begin
                // retire the held second write of the previous swap
                o_cmd.flush      = 1'b1;
                o_cmd.rd_pair    = i_status.pair_ok;
                o_cmd.next_chunk = !i_status.pair_ok && !i_status.tail;
            end
            kpsc_pkg::ST_WRITE: begin
                o_cmd.wr_first = 1'b1;
            end
            kpsc_pkg::ST_LOOKUP: begin
                o_cmd.rd_look = 1'b1;
            end
            kpsc_pkg::ST_RESULT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/kpsc_dp.sv -----
// ----------------------------------------------------------------------------
// kpsc_dp
// Datapath: permutation and inverse memories, swap pointers, key, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module kpsc_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  kpsc_pkg::t_ctrl_cmd     i_cmd,
    output kpsc_pkg::t_dp_status    o_status,
    kpsc_in_if.sink                 i_data_ch,
    kpsc_out_if.source              o_result_ch,
    kpsc_cfg_if.sink                i_cfg_ch
);

    localparam int unsigned AW = kpsc_pkg::ADDR_W;
    localparam int unsigned PW = kpsc_pkg::PTR_W;
    localparam int unsigned BW = kpsc_pkg::BYTE_W;
    localparam int unsigned KW = kpsc_pkg::KEY_W;
    localparam int unsigned XW = kpsc_pkg::KIDX_W;

    // tables
    logic [BW-1:0] mem_fwd [kpsc_pkg::TABLE_DEPTH];
    logic [BW-1:0] mem_inv [kpsc_pkg::TABLE_DEPTH];

    // configuration
    logic [KW-1:0] r_key_low;
    logic [KW-1:0] r_key_high;
    logic          r_decrypt;

    // round state
    logic [XW-1:0] r_kidx;
    logic [BW-1:0] r_pos;
    logic [BW-1:0] r_size;
    logic [PW-1:0] r_base;
    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_hi;
    logic          r_tail;
    logic [AW-1:0] r_clr;

    // held second write of a swap
    logic          r_pend;
    logic [AW-1:0] r_pa;
    logic [AW-1:0] r_pb;
    logic [BW-1:0] r_px;
    logic [BW-1:0] r_py;

    // registered read data
    logic [BW-1:0] r_fa;
    logic [BW-1:0] r_fb;
    logic [BW-1:0] r_ia;

    // result register
    logic          r_out_valid;
    logic [BW-1:0] r_res;

    logic [2*KW-1:0] w_key_all;
    logic [BW-1:0]   w_key_byte;
    logic [BW-1:0]   w_size;
    logic [PW-1:0]   w_nb;
    logic            w_fits;
    logic [XW:0]     w_kidx_inc;
    logic [AW-1:0]   w_raddr_a;
    logic            w_rd_fwd;
    logic            w_fwd_we;
    logic [AW-1:0]   w_fwd_waddr;
    logic [BW-1:0]   w_fwd_wdata;
    logic            w_inv_we;
    logic [AW-1:0]   w_inv_waddr;
    logic [BW-1:0]   w_inv_wdata;
    logic            w_out_xfer;

    // key byte and chunk size
    assign w_key_all  = {r_key_high, r_key_low};
    assign w_key_byte = w_key_all[{r_kidx, 3'b000} +: BW];
    assign w_size     = (w_key_byte < BW'(kpsc_pkg::MIN_CHUNK)) ?
                        BW'(kpsc_pkg::MIN_CHUNK) : w_key_byte;
    assign w_kidx_inc = {1'b0, r_kidx} + (XW+1)'(1);

    // next chunk start and whether a whole chunk still fits
    assign w_nb   = r_base + {1'b0, r_size};
    assign w_fits = ({1'b0, w_nb} + {2'b00, r_size}) <= (PW+1)'(kpsc_pkg::TABLE_DEPTH);

    // status
    assign o_status.clr_last = (r_clr == {AW{1'b1}});
    assign o_status.pair_ok  = (r_lo < r_hi);
    assign o_status.tail     = r_tail;
    assign o_status.out_free = !r_out_valid || o_result_ch.ready;

    // channel handshakes
    assign i_data_ch.ready         = i_cmd.in_ready;
    assign i_cfg_ch.ready          = 1'b1;
    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.result_byte = r_res;
    assign w_out_xfer              = r_out_valid && o_result_ch.ready;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.reg_index)
                kpsc_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_ch.wdata;
                kpsc_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_ch.wdata;
                kpsc_pkg::CFG_DECRYPT:  r_decrypt  <= i_cfg_ch.wdata[0];
                default: begin
                end
            endcase
        end
    end

    // clear counter, key index, tail flag, pending-write flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_kidx <= '0;
            r_pend <= 1'b0;
            r_tail <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.start) begin
                r_kidx <= (w_kidx_inc >= (XW+1)'(kpsc_pkg::KEY_COUNT)) ?
                          '0 : w_kidx_inc[XW-1:0];
                r_tail <= 1'b0;
            end else if (i_cmd.next_chunk) begin
                r_tail <= !w_fits;
            end
            if (i_cmd.wr_first) begin
                r_pend <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend <= 1'b0;
            end
        end
    end

    // chunk walk and swap pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos  <= i_data_ch.data_byte;
            r_size <= w_size;
            r_base <= '0;
            r_lo   <= '0;
            r_hi   <= {1'b0, w_size} - PW'(1);
        end else if (i_cmd.next_chunk) begin
            r_base <= w_nb;
            r_lo   <= w_nb;
            r_hi   <= w_fits ? (w_nb + {1'b0, r_size} - PW'(1)) :
                               PW'(kpsc_pkg::TABLE_DEPTH - 1);
        end else if (i_cmd.wr_first) begin
            r_lo <= r_lo + PW'(1);
            r_hi <= r_hi - PW'(1);
        end
    end

    // hold the second half of the swap for the next pair cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_first) begin
            r_pa <= r_lo[AW-1:0];
            r_pb <= r_hi[AW-1:0];
            r_px <= r_fa;
            r_py <= r_fb;
        end
    end

    // write port selection
    always_comb begin
        w_fwd_we    = 1'b0;
        w_fwd_waddr = r_clr;
        w_fwd_wdata = r_clr;
        w_inv_we    = 1'b0;
        w_inv_waddr = r_clr;
        w_inv_wdata = r_clr;
        if (i_cmd.clr_wr) begin
            w_fwd_we = 1'b1;
            w_inv_we = 1'b1;
        end else if (i_cmd.wr_first) begin
            w_fwd_we    = 1'b1;
            w_fwd_waddr = r_lo[AW-1:0];
            w_fwd_wdata = r_fb;
            w_inv_we    = 1'b1;
            w_inv_waddr = r_fa;
            w_inv_wdata = r_hi[AW-1:0];
        end else if (i_cmd.flush && r_pend) begin
            w_fwd_we    = 1'b1;
            w_fwd_waddr = r_pb;
            w_fwd_wdata = r_px;
            w_inv_we    = 1'b1;
            w_inv_waddr = r_py;
            w_inv_wdata = r_pa;
        end
    end

    // read address selection
    assign w_raddr_a = i_cmd.rd_look ? r_pos : r_lo[AW-1:0];
    assign w_rd_fwd  = i_cmd.rd_pair || i_cmd.rd_look;

    // forward table
    always_ff @(posedge i_clk) begin
        if (w_fwd_we) mem_fwd[w_fwd_waddr] <= w_fwd_wdata;
        if (w_rd_fwd) r_fa <= mem_fwd[w_raddr_a];
        if (i_cmd.rd_pair) r_fb <= mem_fwd[r_hi[AW-1:0]];
    end

    // inverse table
    always_ff @(posedge i_clk) begin
        if (w_inv_we) mem_inv[w_inv_waddr] <= w_inv_wdata;
        if (i_cmd.rd_look) r_ia <= mem_inv[r_pos];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_res <= r_decrypt ? r_ia : r_fa;
    end

endmodule

`default_nettype wire

// ----- design/keyed_permutation_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// keyed_permutation_stream_cipher
// Byte stream cipher over a key-driven 256-entry permutation and its inverse.
// ----------------------------------------------------------------------------
//  channel      dir  fields                 transfer when
//  i_data_ch    in   data_byte[7:0]         valid && ready
//  o_result_ch  out  result_byte[7:0]       valid && ready
//  i_cfg_ch     in   reg_index[1:0], wdata  valid && ready (ready held high)
//
//  After reset a clearing pass writes all 256 entries of both tables with
//  the identity; no byte is taken meanwhile. Each byte then runs a start,
//  a pair and a write step for each swap (one write port per table), a step
//  for each chunk, and a final check, lookup and result load.
//  One byte is processed at a time; a result waiting in the output register
//  stalls only the final load of the following byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module keyed_permutation_stream_cipher (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    kpsc_in_if.sink     i_data_ch,
    kpsc_out_if.source  o_result_ch,
    kpsc_cfg_if.sink    i_cfg_ch
);

    kpsc_pkg::t_ctrl_cmd  w_cmd;
    kpsc_pkg::t_dp_status w_status;

    // sequencer
    kpsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_data_ch.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // tables and registers
    kpsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_data_ch   (i_data_ch),
        .o_result_ch (o_result_ch),
        .i_cfg_ch    (i_cfg_ch)
    );

    // an accepted byte starts a round, so input is closed the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_data_ch.valid && i_data_ch.ready, !i_data_ch.ready)
    // a result appears only from a load issued by the sequencer
    `ASSERT_IMPLIES(a_result_from_load, i_clk, i_rst_n, $rose(o_result_ch.valid), $past(w_cmd.load_out))
    // tables are never written while waiting for input
    `ASSERT_NEVER(a_no_write_idle, i_clk, i_rst_n, w_cmd.in_ready && (w_cmd.clr_wr || w_cmd.wr_first || w_cmd.flush))

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed permutation stream cipher. Bytes are
// sent through the data channel while a local copy of the permutation, its
// inverse and the key position predicts each result byte. Results are
// compared in order. Directed cases cover the reset key, the spare register
// index, a full key cycle with edge chunk sizes, a mode switch and an output
// hold. Random phases then change key and mode between bursts of bytes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned TOTAL_BYTES    = 1700;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned DRAIN_CYCLES   = 400;
    // index past the last register; writes to it must be dropped
    localparam logic [kpsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kpsc_in_if  data_ch ();
    kpsc_out_if result_ch ();
    kpsc_cfg_if cfg_ch ();

    keyed_permutation_stream_cipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_ch   (data_ch),
        .o_result_ch (result_ch),
        .i_cfg_ch    (cfg_ch)
    );

    // predicted cipher state
    logic [kpsc_pkg::BYTE_W-1:0] perm_fwd [0:kpsc_pkg::TABLE_DEPTH-1];
    logic [kpsc_pkg::BYTE_W-1:0] perm_inv [0:kpsc_pkg::TABLE_DEPTH-1];
    logic [kpsc_pkg::KIDX_W-1:0] key_pos;
    logic [kpsc_pkg::KEY_W-1:0]  key_lo_q;
    logic [kpsc_pkg::KEY_W-1:0]  key_hi_q;
    logic                        decrypt_q;

    logic [kpsc_pkg::BYTE_W-1:0] pending_result_bytes [$];
    logic [kpsc_pkg::BYTE_W-1:0] wanted_byte;
    int unsigned       mismatch_count = 0;
    int unsigned       bytes_sent     = 0;
    int unsigned       settings_run   = 0;
    int unsigned       idle_run       = 0;
    int unsigned       hold_left      = 0;
    bit                calm           = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reverse entries base .. base+len-1 of the permutation, keeping the
    // inverse in step with every swap.
    function automatic void reverse_run(int unsigned base, int unsigned len);
        logic [kpsc_pkg::BYTE_W-1:0] a;
        logic [kpsc_pkg::BYTE_W-1:0] b;
        logic [kpsc_pkg::BYTE_W-1:0] x;
        logic [kpsc_pkg::BYTE_W-1:0] y;
        for (int unsigned i = 0; i < len / 2; i++) begin
            a = kpsc_pkg::BYTE_W'(base + i);
            b = kpsc_pkg::BYTE_W'(base + len - 1 - i);
            x = perm_fwd[a];
            y = perm_fwd[b];
            perm_fwd[a] = y;
            perm_fwd[b] = x;
            perm_inv[x] = b;
            perm_inv[y] = a;
        end
    endfunction

    // One round under the current key byte, then the table lookup.
    function automatic logic [kpsc_pkg::BYTE_W-1:0] cipher_byte(
        logic [kpsc_pkg::BYTE_W-1:0] pos);
        logic [2*kpsc_pkg::KEY_W-1:0] key_all;
        logic [kpsc_pkg::BYTE_W-1:0]  kbyte;
        int unsigned                  chunk;
        int unsigned                  base;
        key_all = {key_hi_q, key_lo_q};
        kbyte   = key_all[key_pos*8 +: 8];
        chunk   = (kbyte < kpsc_pkg::MIN_CHUNK) ? kpsc_pkg::MIN_CHUNK : kbyte;
        base    = 0;
        while (base + chunk <= kpsc_pkg::TABLE_DEPTH) begin
            reverse_run(base, chunk);
            base += chunk;
        end
        // a tail of one entry stays put
        if (kpsc_pkg::TABLE_DEPTH - base > 1)
            reverse_run(base, kpsc_pkg::TABLE_DEPTH - base);
        key_pos = (key_pos == kpsc_pkg::KEY_COUNT - 1) ? '0 : key_pos + 1'b1;
        return decrypt_q ? perm_inv[pos] : perm_fwd[pos];
    endfunction

    // Pick a key word: zero, all ones, random, edge chunk sizes or small sizes.
    function automatic logic [kpsc_pkg::KEY_W-1:0] random_key_word(int unsigned style);
        logic [kpsc_pkg::KEY_W-1:0] word;
        word = '0;
        case (style)
            0: word = '0;
            1: word = '1;
            2: word = {$urandom, $urandom};
            3: begin
                for (int i = 0; i < 8; i++) begin
                    case ($urandom_range(12))
                        0:  word[i*8 +: 8] = 8'd0;
                        1:  word[i*8 +: 8] = 8'd1;
                        2:  word[i*8 +: 8] = 8'd3;
                        3:  word[i*8 +: 8] = 8'd5;
                        4:  word[i*8 +: 8] = 8'd15;
                        5:  word[i*8 +: 8] = 8'd17;
                        6:  word[i*8 +: 8] = 8'd51;
                        7:  word[i*8 +: 8] = 8'd85;
                        8:  word[i*8 +: 8] = 8'd127;
                        9:  word[i*8 +: 8] = 8'd128;
                        10: word[i*8 +: 8] = 8'd254;
                        11: word[i*8 +: 8] = 8'd255;
                        default: word[i*8 +: 8] = 8'($urandom_range(255));
                    endcase
                end
            end
            default: begin
                for (int i = 0; i < 8; i++)
                    word[i*8 +: 8] = 8'($urandom_range(16));
            end
        endcase
        return word;
    endfunction

    // Check results, predict on accepted bytes and track register writes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_result_bytes.size() == 0) begin
                    $display("%0t: result_byte expected none, got 0x%02h",
                             $time, result_ch.result_byte);
                    mismatch_count++;
                end else begin
                    wanted_byte = pending_result_bytes.pop_front();
                    if (result_ch.result_byte !== wanted_byte) begin
                        $display("%0t: result_byte expected 0x%02h, got 0x%02h",
                                 $time, wanted_byte, result_ch.result_byte);
                        mismatch_count++;
                    end
                end
            end
            if (data_ch.valid && data_ch.ready)
                pending_result_bytes.push_back(cipher_byte(data_ch.data_byte));
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.reg_index)
                    kpsc_pkg::CFG_KEY_LOW:  key_lo_q  = cfg_ch.wdata;
                    kpsc_pkg::CFG_KEY_HIGH: key_hi_q  = cfg_ch.wdata;
                    kpsc_pkg::CFG_DECRYPT:  decrypt_q = cfg_ch.wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // Abort when no transfer happens on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (data_ch.valid && data_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_run);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, or a long hold when requested.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            result_ch.ready = 1'b0;
            hold_left--;
        end else begin
            result_ch.ready = calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_byte(input logic [kpsc_pkg::BYTE_W-1:0] value);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 7) begin
            data_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        data_ch.valid     = 1'b1;
        data_ch.data_byte = value;
        do @(posedge i_clk); while (!data_ch.ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [kpsc_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [kpsc_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wdata     = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drop valid and hold until every predicted byte has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        data_ch.valid = 1'b0;
        while (pending_result_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // All-zero key after reset: chunk size two from the first byte.
    task automatic test_reset_key();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        wait_drained();
    endtask

    // A write to the spare index must leave key and mode alone.
    task automatic test_spare_register();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        send_byte(8'h01);
        wait_drained();
    endtask

    // Edge chunk sizes over a full key cycle, then wrap to key byte 0.
    task automatic test_key_cycle();
        write_reg(kpsc_pkg::CFG_KEY_LOW,  64'h8055_110F_0503_FF01);
        write_reg(kpsc_pkg::CFG_KEY_HIGH, 64'hFE7F_4033_1002_AA00);
        repeat (kpsc_pkg::KEY_COUNT + 1)
            send_byte(8'($urandom_range(255)));
        wait_drained();
        settings_run++;
    endtask

    // Switch to decrypt and back; tables and key position carry over.
    task automatic test_mode_switch();
        write_reg(kpsc_pkg::CFG_DECRYPT, '1);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drained();
        write_reg(kpsc_pkg::CFG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
        send_byte(8'h7F);
        wait_drained();
        settings_run += 2;
    endtask

    // Hold the receiver off while bytes keep coming, so the input stalls.
    task automatic test_output_backpressure();
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        repeat (6)
            send_byte(8'($urandom_range(255)));
        wait_drained();
    endtask

    // Random key and mode per phase, then a burst of random bytes.
    task automatic test_random_settings();
        int unsigned phase;
        int unsigned burst;
        phase = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(kpsc_pkg::CFG_KEY_LOW, random_key_word(phase % 5));
            if (phase == 0 || $urandom_range(3) != 0)
                write_reg(kpsc_pkg::CFG_KEY_HIGH, random_key_word(phase % 5));
            write_reg(kpsc_pkg::CFG_DECRYPT, {$urandom, $urandom});
            if ($urandom_range(7) == 0)
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            // one phase runs without any idling on either side
            calm  = (phase == 1);
            burst = calm ? 150 : $urandom_range(40, 140);
            repeat (burst)
                send_byte(8'($urandom_range(255)));
            wait_drained();
            calm = 1'b0;
            phase++;
            settings_run++;
        end
    endtask

    initial begin
        data_ch.valid      = 1'b0;
        data_ch.data_byte  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = kpsc_pkg::CFG_KEY_LOW;
        cfg_ch.wdata       = '0;
        result_ch.ready    = 1'b0;
        for (int i = 0; i < kpsc_pkg::TABLE_DEPTH; i++) begin
            perm_fwd[i] = kpsc_pkg::BYTE_W'(i);
            perm_inv[i] = kpsc_pkg::BYTE_W'(i);
        end
        key_pos   = '0;
        key_lo_q  = '0;
        key_hi_q  = '0;
        decrypt_q = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_spare_register();
        test_key_cycle();
        test_mode_switch();
        test_output_backpressure();
        test_random_settings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d bytes over %0d key/mode settings in both directions,",
                 bytes_sent, settings_run);
        $display("including a %0d-cycle output hold; %0d mismatches seen.",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
